>>> sv/wsdf_pkg.sv
// shared types and codes for the websocket frame deframer
package wsdf_pkg;

	// request codes
	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_OPEN = 2'd1;
	localparam logic [1:0] REQ_LOST = 2'd2;

	// result kinds
	localparam logic [3:0] KIND_TEXT       = 4'd0;
	localparam logic [3:0] KIND_BINARY     = 4'd1;
	localparam logic [3:0] KIND_PING       = 4'd2;
	localparam logic [3:0] KIND_EMPTY_TEXT = 4'd3;
	localparam logic [3:0] KIND_EMPTY_BIN  = 4'd4;
	localparam logic [3:0] KIND_PONG       = 4'd5;
	localparam logic [3:0] KIND_CLOSE      = 4'd6;
	localparam logic [3:0] KIND_DISCONN    = 4'd7;
	localparam logic [3:0] KIND_ERROR      = 4'd8;

	// frame opcodes
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	// second header byte length escapes
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// configuration
	localparam int           LIMIT_W     = 17;
	localparam logic [16:0]  LIMIT_RESET = 17'd8192;
	localparam logic         REG_LIMIT   = 1'b0;

	// input item
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} req_t;

	// result item
	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] status_code;
		logic        has_close_code;
		logic        last;
	} rsp_t;

endpackage

>>> sv/websocket_frame_deframer.sv
// websocket frame deframer top level: header parse, unmasking and result register
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  request | req_valid / req_ready  | req  (req_type, rx_byte)
//  result  | rsp_valid / rsp_ready  | rsp  (kind, data_byte, status_code,
//          |                        |       has_close_code, last)
//  config  | apb psel/penable/...   | large_frame_limit at address 0
//
// one item per cycle while no result is stalled: the parser state updates at the accepting
// edge and the result, if any, lands in the result register the same edge.
// req_ready is high while the result register is empty or being taken.
// a result waiting on rsp_ready blocks the request side, also for items with no result.
// arst_n clears the link, the parser and the result register and sets the limit to 8192.
module websocket_frame_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  wsdf_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output wsdf_pkg::rsp_t       rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_PAY  = 3'd4
	} phase_t;

	// registers
	logic [wsdf_pkg::LIMIT_W-1:0] limit_q;
	logic           link_open_q;
	phase_t         phase_q;
	logic [3:0]     opcode_q;
	logic           masked_q;
	logic [63:0]    len_q;
	logic [63:0]    rem_q;
	logic [3:0]     left_q;
	logic [31:0]    key_q;
	logic [1:0]     off_q;
	logic [1:0]     pos_q;
	logic [15:0]    code_q;
	logic           rsp_valid_q;
	wsdf_pkg::rsp_t rsp_q;

	// next values
	logic           n_link_open;
	phase_t         n_phase;
	logic [3:0]     n_opcode;
	logic           n_masked;
	logic [63:0]    n_len;
	logic [63:0]    n_rem;
	logic [3:0]     n_left;
	logic [31:0]    n_key;
	logic [1:0]     n_off;
	logic [1:0]     n_pos;
	logic [15:0]    n_code;
	logic           emit;
	wsdf_pkg::rsp_t res;

	logic           acc;
	logic           cfg_wr;
	logic           len_known;
	logic           hdr_done;
	logic [7:0]     key_byte;
	logic [7:0]     dbyte;
	logic           fin;
	logic           small_frame;
	logic           has_code;

	assign acc       = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == wsdf_pkg::REG_LIMIT);

	// register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == wsdf_pkg::REG_LIMIT) begin
			prdata = {{(32 - wsdf_pkg::LIMIT_W){1'b0}}, limit_q};
		end
	end

	// payload byte helpers
	always_comb begin
		unique case (off_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end
	assign dbyte       = req.rx_byte ^ key_byte;
	assign fin         = (rem_q == 64'd1);
	assign small_frame = (len_q[63:wsdf_pkg::LIMIT_W] == '0) &&
		(len_q[wsdf_pkg::LIMIT_W-1:0] < limit_q);
	assign has_code    = (len_q[63:1] != '0);

	// parser next state and result
	always_comb begin
		n_link_open = link_open_q;
		n_phase     = phase_q;
		n_opcode    = opcode_q;
		n_masked    = masked_q;
		n_len       = len_q;
		n_rem       = rem_q;
		n_left      = left_q;
		n_key       = key_q;
		n_off       = off_q;
		n_pos       = pos_q;
		n_code      = code_q;
		emit        = 1'b0;
		res         = '0;
		len_known   = 1'b0;
		hdr_done    = 1'b0;

		unique case (req.req_type)
			wsdf_pkg::REQ_OPEN, wsdf_pkg::REQ_LOST: begin
				// link change restarts the parser
				n_phase  = PH_HDR0;
				n_opcode = '0;
				n_masked = 1'b0;
				n_len    = '0;
				n_rem    = '0;
				n_left   = '0;
				n_key    = '0;
				n_off    = '0;
				n_pos    = '0;
				n_code   = '0;
				if (req.req_type == wsdf_pkg::REQ_OPEN) begin
					n_link_open = 1'b1;
				end else begin
					n_link_open = 1'b0;
					if (link_open_q) begin
						emit     = 1'b1;
						res.kind = (phase_q == PH_PAY) ? wsdf_pkg::KIND_ERROR :
							wsdf_pkg::KIND_DISCONN;
					end
				end
			end
			wsdf_pkg::REQ_BYTE: begin
				if (link_open_q) begin
					unique case (phase_q)
						PH_HDR1: begin
							n_masked = req.rx_byte[7];
							n_key    = '0;
							n_len    = '0;
							if (req.rx_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
								n_left  = 4'd2;
								n_phase = PH_EXT;
							end else if (req.rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
								n_left  = 4'd8;
								n_phase = PH_EXT;
							end else begin
								n_len     = {57'd0, req.rx_byte[6:0]};
								len_known = 1'b1;
							end
						end
						PH_EXT: begin
							n_len  = {len_q[55:0], req.rx_byte};
							n_left = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
							if (n_left == 4'd0) begin
								len_known = 1'b1;
							end
						end
						PH_KEY: begin
							n_key  = {key_q[23:0], req.rx_byte};
							n_left = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
							if (n_left == 4'd0) begin
								hdr_done = 1'b1;
							end
						end
						PH_PAY: begin
							// unmask and route one payload byte
							unique case (opcode_q)
								wsdf_pkg::OP_TEXT: begin
									if (small_frame) begin
										emit          = 1'b1;
										res.kind      = wsdf_pkg::KIND_TEXT;
										res.data_byte = dbyte;
										res.last      = fin;
									end
								end
								wsdf_pkg::OP_BINARY: begin
									emit          = 1'b1;
									res.kind      = wsdf_pkg::KIND_BINARY;
									res.data_byte = dbyte;
									res.last      = fin;
								end
								wsdf_pkg::OP_PING: begin
									if (small_frame) begin
										emit          = 1'b1;
										res.kind      = wsdf_pkg::KIND_PING;
										res.data_byte = dbyte;
										res.last      = fin;
									end else if (fin) begin
										emit     = 1'b1;
										res.kind = wsdf_pkg::KIND_PONG;
									end
								end
								wsdf_pkg::OP_CLOSE: begin
									if (pos_q == 2'd0) begin
										n_code = {dbyte, 8'd0};
									end else if (pos_q == 2'd1) begin
										n_code = {code_q[15:8], code_q[7:0] | dbyte};
									end
									if (fin) begin
										n_link_open        = 1'b0;
										emit               = 1'b1;
										res.kind           = wsdf_pkg::KIND_CLOSE;
										res.has_close_code = has_code;
										res.status_code    = has_code ? n_code : 16'd0;
									end
								end
								default: begin
								end
							endcase
							n_off = off_q + 2'd1;
							n_pos = (pos_q == 2'd2) ? pos_q : pos_q + 2'd1;
							n_rem = rem_q - 64'd1;
							if (fin) begin
								n_off   = '0;
								n_phase = PH_HDR0;
							end
						end
						default: begin
							n_opcode = req.rx_byte[3:0];
							n_phase  = PH_HDR1;
						end
					endcase

					// length known: fetch the key or finish the header
					if (len_known) begin
						if (n_masked) begin
							n_left  = 4'd4;
							n_phase = PH_KEY;
						end else begin
							hdr_done = 1'b1;
						end
					end

					// header complete
					if (hdr_done) begin
						n_off  = '0;
						n_pos  = '0;
						n_code = '0;
						n_left = '0;
						n_rem  = n_len;
						if (n_len != 64'd0) begin
							n_phase = PH_PAY;
						end else begin
							n_phase = PH_HDR0;
							unique case (opcode_q)
								wsdf_pkg::OP_TEXT: begin
									emit     = 1'b1;
									res.kind = wsdf_pkg::KIND_EMPTY_TEXT;
								end
								wsdf_pkg::OP_BINARY: begin
									emit     = 1'b1;
									res.kind = wsdf_pkg::KIND_EMPTY_BIN;
								end
								wsdf_pkg::OP_PING: begin
									emit     = 1'b1;
									res.kind = wsdf_pkg::KIND_PONG;
								end
								wsdf_pkg::OP_CLOSE: begin
									n_link_open = 1'b0;
									emit        = 1'b1;
									res.kind    = wsdf_pkg::KIND_CLOSE;
								end
								default: begin
								end
							endcase
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= wsdf_pkg::LIMIT_RESET;
			link_open_q <= 1'b0;
			phase_q     <= PH_HDR0;
			opcode_q    <= '0;
			masked_q    <= 1'b0;
			len_q       <= '0;
			rem_q       <= '0;
			left_q      <= '0;
			key_q       <= '0;
			off_q       <= '0;
			pos_q       <= '0;
			code_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_wr) begin
				limit_q <= pwdata[wsdf_pkg::LIMIT_W-1:0];
			end
			if (acc) begin
				link_open_q <= n_link_open;
				phase_q     <= n_phase;
				opcode_q    <= n_opcode;
				masked_q    <= n_masked;
				len_q       <= n_len;
				rem_q       <= n_rem;
				left_q      <= n_left;
				key_q       <= n_key;
				off_q       <= n_off;
				pos_q       <= n_pos;
				code_q      <= n_code;
			end
			if (acc && emit) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// checks
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !req_ready)
		else $error("item accepted while result stalled");

	a_close_ends_link: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit && res.kind == wsdf_pkg::KIND_CLOSE) |=> !link_open_q)
		else $error("link still open after close");

	a_payload_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAY) |-> (rem_q != 64'd0))
		else $error("payload phase with nothing remaining");

	a_data_only_for_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.kind != wsdf_pkg::KIND_TEXT &&
		rsp_q.kind != wsdf_pkg::KIND_BINARY && rsp_q.kind != wsdf_pkg::KIND_PING)
		|-> (rsp_q.data_byte == 8'd0 && !rsp_q.last))
		else $error("data on a non-byte result");

endmodule

>>> tb/testbench.sv
// testbench for the websocket frame deframer: directed rows, then random frames
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// opcodes and request code the package leaves out
	localparam logic [3:0]     OP_CONT   = 4'h0;
	localparam logic [3:0]     OP_PONG   = 4'hA;
	localparam logic [1:0]     REQ_BOGUS = 2'd3;
	localparam wsdf_pkg::rsp_t NO_RSP    = '0;
	localparam int             SETTLE    = 4;

	typedef enum logic [2:0] {ST_HEAD0, ST_HEAD1, ST_EXTLEN, ST_KEY, ST_BODY} hdr_stage_t;

	typedef struct packed {
		wsdf_pkg::req_t item;
		logic           pinned;
		logic           pinned_out;
		wsdf_pkg::rsp_t pinned_rsp;
	} step_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	wsdf_pkg::req_t req_item;
	logic           rsp_valid;
	logic           rsp_ready;
	wsdf_pkg::rsp_t rsp_item;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [2:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	// deframer state as predicted
	logic        link_up;
	hdr_stage_t  stage;
	logic [3:0]  fr_op;
	logic        fr_masked;
	logic [63:0] fr_len;
	logic [3:0]  hdr_left;
	logic [31:0] fr_key;
	logic [63:0] fr_pos;
	logic [15:0] close_hold;
	logic [16:0] size_limit;

	wsdf_pkg::rsp_t deframed_q[$];
	logic [7:0]     frame_bytes[$];
	logic           pinned;
	logic           pinned_out;
	wsdf_pkg::rsp_t pinned_rsp;
	logic           calm;
	int             failures;
	int             items_used;
	int             results_seen;

	// directed rows: typed results only where obvious
	step_row_t directed_rows [27] = '{
		'{'{wsdf_pkg::REQ_LOST, 8'h00}, 1'b1, 1'b0, NO_RSP},
		'{'{REQ_BOGUS, 8'hFF}, 1'b1, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_OPEN, 8'h00}, 1'b1, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_LOST, 8'h00}, 1'b1, 1'b1,
			'{wsdf_pkg::KIND_DISCONN, 8'h00, 16'h0000, 1'b0, 1'b0}},
		'{'{wsdf_pkg::REQ_OPEN, 8'hFF}, 1'b1, 1'b0, NO_RSP},
		// text with fin and rsv bits set, empty
		'{'{wsdf_pkg::REQ_BYTE, 8'hF1}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'h00}, 1'b1, 1'b1,
			'{wsdf_pkg::KIND_EMPTY_TEXT, 8'h00, 16'h0000, 1'b0, 1'b0}},
		// one-byte binary
		'{'{wsdf_pkg::REQ_BYTE, 8'h82}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'h01}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b1, 1'b1,
			'{wsdf_pkg::KIND_BINARY, 8'hFF, 16'h0000, 1'b0, 1'b1}},
		// close with code 1000
		'{'{wsdf_pkg::REQ_BYTE, 8'h88}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'h02}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'h03}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hE8}, 1'b1, 1'b1,
			'{wsdf_pkg::KIND_CLOSE, 8'h00, 16'h03E8, 1'b1, 1'b0}},
		// binary with all-ones 64-bit length, then loss mid payload
		'{'{wsdf_pkg::REQ_OPEN, 8'h00}, 1'b1, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'h02}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'h7F}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'hFF}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_BYTE, 8'h00}, 1'b0, 1'b0, NO_RSP},
		'{'{wsdf_pkg::REQ_LOST, 8'h00}, 1'b1, 1'b1,
			'{wsdf_pkg::KIND_ERROR, 8'h00, 16'h0000, 1'b0, 1'b0}}
	};

	websocket_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic wsdf_pkg::rsp_t make_rsp(input logic [3:0] k, input logic [7:0] d,
			input logic [15:0] c, input logic h, input logic l);
		wsdf_pkg::rsp_t x;
		x.kind = k;
		x.data_byte = d;
		x.status_code = c;
		x.has_close_code = h;
		x.last = l;
		return x;
	endfunction

	function automatic void clear_parser();
		stage = ST_HEAD0;
		fr_op = '0;
		fr_masked = 1'b0;
		fr_len = '0;
		hdr_left = '0;
		fr_key = '0;
		fr_pos = '0;
		close_hold = '0;
	endfunction

	// header complete: empty frames report here
	function automatic logic finish_header(output wsdf_pkg::rsp_t r);
		r = NO_RSP;
		fr_pos = '0;
		close_hold = '0;
		hdr_left = '0;
		if (fr_len != 0) begin
			stage = ST_BODY;
			return 1'b0;
		end
		stage = ST_HEAD0;
		case (fr_op)
			wsdf_pkg::OP_TEXT: begin
				r = make_rsp(wsdf_pkg::KIND_EMPTY_TEXT, 8'h00, 16'h0000, 1'b0, 1'b0);
				return 1'b1;
			end
			wsdf_pkg::OP_BINARY: begin
				r = make_rsp(wsdf_pkg::KIND_EMPTY_BIN, 8'h00, 16'h0000, 1'b0, 1'b0);
				return 1'b1;
			end
			wsdf_pkg::OP_PING: begin
				r = make_rsp(wsdf_pkg::KIND_PONG, 8'h00, 16'h0000, 1'b0, 1'b0);
				return 1'b1;
			end
			wsdf_pkg::OP_CLOSE: begin
				link_up = 1'b0;
				r = make_rsp(wsdf_pkg::KIND_CLOSE, 8'h00, 16'h0000, 1'b0, 1'b0);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// length known: mask key next, or header done
	function automatic logic length_known(output wsdf_pkg::rsp_t r);
		r = NO_RSP;
		if (fr_masked) begin
			hdr_left = 4'd4;
			stage = ST_KEY;
			return 1'b0;
		end
		return finish_header(r);
	endfunction

	// one payload byte: unmask and route by opcode
	function automatic logic body_byte(input logic [7:0] b, output wsdf_pkg::rsp_t r);
		logic [7:0] d;
		logic       fin;
		logic       below;
		logic       got;
		r = NO_RSP;
		got = 1'b0;
		d = b ^ fr_key[8 * (3 - int'(fr_pos[1:0])) +: 8];
		fin = (fr_pos == fr_len - 64'd1);
		below = (fr_len < 64'(size_limit));
		case (fr_op)
			wsdf_pkg::OP_TEXT: begin
				if (below) begin
					r = make_rsp(wsdf_pkg::KIND_TEXT, d, 16'h0000, 1'b0, fin);
					got = 1'b1;
				end
			end
			wsdf_pkg::OP_BINARY: begin
				r = make_rsp(wsdf_pkg::KIND_BINARY, d, 16'h0000, 1'b0, fin);
				got = 1'b1;
			end
			wsdf_pkg::OP_PING: begin
				if (below) begin
					r = make_rsp(wsdf_pkg::KIND_PING, d, 16'h0000, 1'b0, fin);
					got = 1'b1;
				end else if (fin) begin
					r = make_rsp(wsdf_pkg::KIND_PONG, 8'h00, 16'h0000, 1'b0, 1'b0);
					got = 1'b1;
				end
			end
			wsdf_pkg::OP_CLOSE: begin
				if (fr_pos == 0)
					close_hold = {d, 8'h00};
				else if (fr_pos == 1)
					close_hold = close_hold | {8'h00, d};
				if (fin) begin
					link_up = 1'b0;
					r = make_rsp(wsdf_pkg::KIND_CLOSE, 8'h00,
						(fr_len >= 2) ? close_hold : 16'h0000, fr_len >= 2, 1'b0);
					got = 1'b1;
				end
			end
			default: ;
		endcase
		fr_pos = fr_pos + 64'd1;
		if (fin) begin
			fr_pos = '0;
			stage = ST_HEAD0;
		end
		return got;
	endfunction

	// received byte on an open link
	function automatic logic take_byte(input logic [7:0] b, output wsdf_pkg::rsp_t r);
		r = NO_RSP;
		case (stage)
			ST_HEAD1: begin
				fr_masked = b[7];
				fr_key = '0;
				fr_len = '0;
				if (b[6:0] == wsdf_pkg::LEN_EXT16 || b[6:0] == wsdf_pkg::LEN_EXT64) begin
					hdr_left = (b[6:0] == wsdf_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
					stage = ST_EXTLEN;
					return 1'b0;
				end
				fr_len = 64'(b[6:0]);
				return length_known(r);
			end
			ST_EXTLEN: begin
				fr_len = {fr_len[55:0], b};
				if (hdr_left != 0)
					hdr_left = hdr_left - 4'd1;
				if (hdr_left != 0)
					return 1'b0;
				return length_known(r);
			end
			ST_KEY: begin
				fr_key = {fr_key[23:0], b};
				if (hdr_left != 0)
					hdr_left = hdr_left - 4'd1;
				if (hdr_left != 0)
					return 1'b0;
				return finish_header(r);
			end
			ST_BODY: return body_byte(b, r);
			default: begin
				fr_op = b[3:0];
				stage = ST_HEAD1;
				return 1'b0;
			end
		endcase
	endfunction

	// predicted result of one accepted item
	function automatic logic deframe(input wsdf_pkg::req_t it, output wsdf_pkg::rsp_t r);
		r = NO_RSP;
		case (it.req_type)
			wsdf_pkg::REQ_OPEN: begin
				items_used++;
				link_up = 1'b1;
				clear_parser();
				return 1'b0;
			end
			wsdf_pkg::REQ_LOST: begin
				if (!link_up)
					return 1'b0;
				items_used++;
				r = make_rsp((stage == ST_BODY) ? wsdf_pkg::KIND_ERROR : wsdf_pkg::KIND_DISCONN,
					8'h00, 16'h0000, 1'b0, 1'b0);
				link_up = 1'b0;
				clear_parser();
				return 1'b1;
			end
			wsdf_pkg::REQ_BYTE: begin
				if (!link_up)
					return 1'b0;
				items_used++;
				return take_byte(it.rx_byte, r);
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic check_result(input wsdf_pkg::rsp_t got);
		wsdf_pkg::rsp_t want;
		if (deframed_q.size() == 0) begin
			$error("result with none expected: kind %0d data %h", got.kind, got.data_byte);
			failures++;
			return;
		end
		want = deframed_q.pop_front();
		results_seen++;
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
			failures++;
		end
		if (got.data_byte !== want.data_byte) begin
			$error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
			failures++;
		end
		if (got.status_code !== want.status_code) begin
			$error("status_code: expected %h, got %h", want.status_code, got.status_code);
			failures++;
		end
		if (got.has_close_code !== want.has_close_code) begin
			$error("has_close_code: expected %b, got %b", want.has_close_code,
				got.has_close_code);
			failures++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %b, got %b", want.last, got.last);
			failures++;
		end
	endtask

	// results are checked, then the accepted item is predicted
	always @(posedge clk) begin : monitor
		wsdf_pkg::rsp_t predicted;
		logic           produced;
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_result(rsp_item);
			if (req_valid && req_ready) begin
				produced = deframe(req_item, predicted);
				if (pinned) begin
					if (pinned_out)
						deframed_q.push_back(pinned_rsp);
				end else if (produced) begin
					deframed_q.push_back(predicted);
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		rsp_ready <= (!calm && $urandom_range(99) < 12) ? 1'b0 : 1'b1;
	end

	// offer one item and hold it until taken; short idles keep the sender about 12% idle
	task automatic push_item(input logic [1:0] rt, input logic [7:0] b);
		if (!calm && $urandom_range(99) < 4) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_item.req_type = rt;
		req_item.rx_byte = b;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// let every expected result come out
	task automatic settle();
		req_valid = 1'b0;
		while (deframed_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {wsdf_pkg::REG_LIMIT, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_limit();
		logic [31:0] rd;
		apb_cycle(1'b0, 32'h0, rd);
		if (rd !== 32'(size_limit)) begin
			$error("large_frame_limit readback: expected %0d, got %0d", size_limit, rd);
			failures++;
		end
	endtask

	task automatic set_limit(input logic [16:0] v);
		logic [31:0] rd;
		apb_cycle(1'b1, 32'(v), rd);
		size_limit = v;
		check_limit();
	endtask

	// random frame into frame_bytes
	task automatic pick_frame();
		logic [3:0]  op;
		logic [31:0] mkey;
		logic [63:0] l64;
		logic        use_mask;
		int          r;
		int          len;
		int          form;
		int          i;
		r = $urandom_range(99);
		if (r < 30)
			op = wsdf_pkg::OP_TEXT;
		else if (r < 55)
			op = wsdf_pkg::OP_BINARY;
		else if (r < 75)
			op = wsdf_pkg::OP_PING;
		else if (r < 82)
			op = wsdf_pkg::OP_CLOSE;
		else if (r < 88)
			op = OP_PONG;
		else if (r < 94)
			op = OP_CONT;
		else
			op = {1'($urandom_range(1)), 3'($urandom_range(3, 7))};
		r = $urandom_range(99);
		if (op == wsdf_pkg::OP_CLOSE)
			len = $urandom_range(0, 4);
		else if (r < 60)
			len = $urandom_range(0, 12);
		else if (r < 90)
			len = $urandom_range(0, 40);
		else if ($urandom_range(1))
			len = $urandom_range(120, 135);
		else
			len = $urandom_range(100, 300);
		r = $urandom_range(99);
		if (len > 125)
			form = 1 + $urandom_range(1);
		else
			form = (r < 75) ? 0 : (r < 90) ? 1 : 2;
		use_mask = $urandom_range(1);
		mkey = $urandom;
		l64 = 64'(len);
		frame_bytes.delete();
		frame_bytes.push_back({4'($urandom_range(15)), op});
		case (form)
			0: frame_bytes.push_back({use_mask, l64[6:0]});
			1: begin
				frame_bytes.push_back({use_mask, wsdf_pkg::LEN_EXT16});
				frame_bytes.push_back(l64[15:8]);
				frame_bytes.push_back(l64[7:0]);
			end
			default: begin
				frame_bytes.push_back({use_mask, wsdf_pkg::LEN_EXT64});
				for (i = 7; i >= 0; i--)
					frame_bytes.push_back(l64[8 * i +: 8]);
			end
		endcase
		if (use_mask)
			for (i = 3; i >= 0; i--)
				frame_bytes.push_back(mkey[8 * i +: 8]);
		for (i = 0; i < len; i++)
			frame_bytes.push_back(8'($urandom_range(255)));
	endtask

	// mostly whole frames; some cut short, some noise, some drains
	task automatic random_step();
		int roll;
		int cut;
		int k;
		if (!link_up)
			push_item(wsdf_pkg::REQ_OPEN, 8'($urandom_range(255)));
		roll = $urandom_range(99);
		if (roll < 85) begin
			pick_frame();
			foreach (frame_bytes[k])
				push_item(wsdf_pkg::REQ_BYTE, frame_bytes[k]);
		end else if (roll < 92) begin
			pick_frame();
			cut = $urandom_range(1, frame_bytes.size() - 1);
			for (k = 0; k < cut; k++)
				push_item(wsdf_pkg::REQ_BYTE, frame_bytes[k]);
			push_item($urandom_range(1) ? wsdf_pkg::REQ_LOST : wsdf_pkg::REQ_OPEN,
				8'($urandom_range(255)));
		end else if (roll < 97) begin
			push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
			if (link_up)
				push_item(wsdf_pkg::REQ_OPEN, 8'($urandom_range(255)));
		end else begin
			settle();
		end
	endtask

	initial begin : stimulus
		logic [16:0] limits [5];
		int ph;
		int goal;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		rsp_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pinned = 1'b0;
		pinned_out = 1'b0;
		pinned_rsp = NO_RSP;
		calm = 1'b0;
		failures = 0;
		items_used = 0;
		results_seen = 0;
		link_up = 1'b0;
		size_limit = wsdf_pkg::LIMIT_RESET;
		clear_parser();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_limit();

		// directed rows
		foreach (directed_rows[ph]) begin
			pinned = directed_rows[ph].pinned;
			pinned_out = directed_rows[ph].pinned_out;
			pinned_rsp = directed_rows[ph].pinned_rsp;
			push_item(directed_rows[ph].item.req_type, directed_rows[ph].item.rx_byte);
		end
		pinned = 1'b0;

		// random frames under several limits; the quiet phase has no idling
		limits = '{wsdf_pkg::LIMIT_RESET, 17'd1, 17'h10000, 17'($urandom_range(2, 24)),
			17'($urandom_range(2, 24))};
		for (ph = 0; ph < 5; ph++) begin
			settle();
			if (ph != 0)
				set_limit(limits[ph]);
			calm = (ph == 2);
			goal = items_used + 215;
			while (items_used < goal)
				random_step();
		end
		calm = 1'b0;
		req_valid = 1'b0;
		while (deframed_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d items through open, loss, header and payload paths, %0d results compared",
			items_used, results_seen);
		$display("limits 8192, 1, 65536, %0d and %0d, with idles and stalls on both sides",
			limits[3], limits[4]);
		if (failures == 0)
			$display("websocket_frame_deframer verification clean");
		else
			$display("websocket_frame_deframer verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("websocket_frame_deframer verification failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/wsdf_pkg.sv
sv/websocket_frame_deframer.sv
tb/testbench.sv
